FILE: hdl/avclp_pkg.sv
// avclp_pkg: shared types and constants of the length-prefix to start-code converter
// no dependencies; imported by every module of the block
package avclp_pkg;

  // codec id of AVC in the low nibble of payload byte 0
  localparam logic [3:0] AVC_CODEC = 4'd7;

  // packet types of the AVC video tag
  localparam logic [7:0] PKT_CONFIG = 8'd0;
  localparam logic [7:0] PKT_NALU   = 8'd1;

  // header offsets inside the tag payload
  localparam logic [3:0] NAL_HDR_LAST  = 4'd4;
  localparam logic [3:0] CFG_LEN_SIZE  = 4'd9;
  localparam logic [3:0] CFG_HDR_LAST  = 4'd10;
  localparam logic [3:0] OFFSET_SAT    = 4'd15;

  // parameter set length fields are two bytes wide
  localparam logic [2:0] PS_LEN_BYTES  = 3'd2;
  localparam logic [2:0] LEN_SIZE_RST  = 3'd4;

  // start code bytes
  localparam logic [7:0] SC_ZERO_BYTE  = 8'h00;
  localparam logic [7:0] SC_LAST_BYTE  = 8'h01;
  localparam logic [1:0] SC_LAST_IDX   = 2'd3;

  // unit kinds
  localparam logic [1:0] KIND_SPS = 2'd0;
  localparam logic [1:0] KIND_PPS = 2'd1;
  localparam logic [1:0] KIND_NAL = 2'd2;

  // parser phases
  typedef enum logic [3:0] {
    PH_CODEC,
    PH_TYPE,
    PH_NAL_HDR,
    PH_PREFIX,
    PH_NAL_DATA,
    PH_CFG_HDR,
    PH_SPS_LEN,
    PH_SPS_DATA,
    PH_PPS_CNT,
    PH_PPS_LEN,
    PH_PPS_DATA,
    PH_IGNORE
  } phase_e;

  // one result group: a four-beat start code or a single data beat
  typedef struct packed {
    logic       sc;
    logic [1:0] kind;
    logic [7:0] data;
    logic       unit_end;
    logic       truncated;
  } grp_t;

endpackage

FILE: hdl/avclp_if.sv
// avclp_in_if / avclp_out_if: valid-ready channels of the converter
// depends on nothing; used by the top level and the bench side
interface avclp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] tag_byte;
  logic       last_of_tag;

  modport source (output valid, output tag_byte, output last_of_tag, input ready);
  modport sink   (input valid, input tag_byte, input last_of_tag, output ready);
endinterface

interface avclp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       is_start_code;
  logic [1:0] unit_kind;
  logic       unit_end;
  logic       truncated;
  logic       last;

  modport source (output valid, output stream_byte, output is_start_code,
                  output unit_kind, output unit_end, output truncated,
                  output last, input ready);
  modport sink   (input valid, input stream_byte, input is_start_code,
                  input unit_kind, input unit_end, input truncated,
                  input last, output ready);
endinterface

FILE: hdl/avclp_parser.sv
// avclp_parser: input register and tag payload parser
// depends on avclp_pkg; hands at most one result group per input beat to avclp_serializer
module avclp_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    tag_byte_i,
  input  logic          last_of_tag_i,
  input  logic          take_i,
  output logic          grp_valid_o,
  output avclp_pkg::grp_t grp_o
);
  import avclp_pkg::*;

  // input register
  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        fire;

  // parser state
  phase_e      phase_q, phase_d;
  logic [3:0]  offset_q, offset_d;
  logic [2:0]  len_size_q, len_size_d;
  logic [31:0] accum_q, accum_d;
  logic [31:0] left_q, left_d;
  logic [2:0]  cnt_q, cnt_d;

  // shared helpers
  logic [31:0] accum_shift;
  logic [2:0]  cnt_inc;
  logic        prefix_done;
  logic        pair_done;
  logic [31:0] unit_len;
  logic        len_zero;
  logic [31:0] left_dec;
  logic        dat_done;
  logic        sc_tr;
  logic        has_grp;

  assign fire       = in_vld_q && take_i;
  assign in_ready_o = !in_vld_q || fire;

  // input beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= tag_byte_i;
      in_last_q <= last_of_tag_i;
    end
  end

  // length accumulation and unit countdown
  assign accum_shift = {accum_q[23:0], in_byte_q};
  assign cnt_inc     = cnt_q + 3'd1;
  assign prefix_done = cnt_inc >= len_size_q;
  assign pair_done   = cnt_inc >= PS_LEN_BYTES;
  assign unit_len    = (phase_q == PH_PREFIX) ? accum_shift : {16'd0, accum_shift[15:0]};
  assign len_zero    = unit_len == 32'd0;
  assign left_dec    = left_q - 32'd1;
  assign dat_done    = left_dec == 32'd0;
  assign sc_tr       = !len_zero && in_last_q;

  // next state
  always_comb begin
    phase_d    = phase_q;
    offset_d   = (offset_q != OFFSET_SAT) ? offset_q + 4'd1 : offset_q;
    len_size_d = len_size_q;
    accum_d    = accum_q;
    left_d     = left_q;
    cnt_d      = cnt_q;
    case (phase_q)
      PH_CODEC: begin
        phase_d = (in_byte_q[3:0] == AVC_CODEC) ? PH_TYPE : PH_IGNORE;
      end
      PH_TYPE: begin
        if (in_byte_q == PKT_CONFIG) begin
          phase_d = PH_CFG_HDR;
        end else if (in_byte_q == PKT_NALU) begin
          phase_d = PH_NAL_HDR;
        end else begin
          phase_d = PH_IGNORE;
        end
      end
      PH_NAL_HDR: begin
        if (offset_q >= NAL_HDR_LAST) begin
          phase_d = PH_PREFIX;
          cnt_d   = 3'd0;
          accum_d = 32'd0;
        end
      end
      PH_PREFIX: begin
        accum_d = accum_shift;
        cnt_d   = cnt_inc;
        if (prefix_done) begin
          phase_d = len_zero ? PH_PREFIX : PH_NAL_DATA;
          left_d  = unit_len;
          cnt_d   = 3'd0;
          accum_d = 32'd0;
        end
      end
      PH_CFG_HDR: begin
        if (offset_q == CFG_LEN_SIZE) begin
          len_size_d = {1'b0, in_byte_q[1:0]} + 3'd1;
        end
        if (offset_q >= CFG_HDR_LAST) begin
          phase_d = PH_SPS_LEN;
          cnt_d   = 3'd0;
          accum_d = 32'd0;
        end
      end
      PH_SPS_LEN, PH_PPS_LEN: begin
        accum_d = {16'd0, accum_shift[15:0]};
        cnt_d   = cnt_inc;
        if (pair_done) begin
          if (phase_q == PH_SPS_LEN) begin
            phase_d = len_zero ? PH_PPS_CNT : PH_SPS_DATA;
          end else begin
            phase_d = len_zero ? PH_IGNORE : PH_PPS_DATA;
          end
          left_d  = unit_len;
          cnt_d   = 3'd0;
          accum_d = 32'd0;
        end
      end
      PH_NAL_DATA: begin
        left_d = left_dec;
        if (dat_done) phase_d = PH_PREFIX;
      end
      PH_SPS_DATA: begin
        left_d = left_dec;
        if (dat_done) phase_d = PH_PPS_CNT;
      end
      PH_PPS_DATA: begin
        left_d = left_dec;
        if (dat_done) phase_d = PH_IGNORE;
      end
      PH_PPS_CNT: begin
        phase_d = PH_PPS_LEN;
        cnt_d   = 3'd0;
        accum_d = 32'd0;
      end
      default: begin
        phase_d = PH_IGNORE;
      end
    endcase
    // end of tag drops everything but the length size
    if (in_last_q) begin
      phase_d  = PH_CODEC;
      offset_d = 4'd0;
      accum_d  = 32'd0;
      left_d   = 32'd0;
      cnt_d    = 3'd0;
    end
  end

  // result group for this beat
  always_comb begin
    has_grp         = 1'b0;
    grp_o.sc        = 1'b1;
    grp_o.kind      = KIND_NAL;
    grp_o.data      = in_byte_q;
    grp_o.unit_end  = len_zero || sc_tr;
    grp_o.truncated = sc_tr;
    case (phase_q)
      PH_PREFIX: begin
        has_grp = prefix_done;
      end
      PH_SPS_LEN: begin
        has_grp    = pair_done;
        grp_o.kind = KIND_SPS;
      end
      PH_PPS_LEN: begin
        has_grp    = pair_done;
        grp_o.kind = KIND_PPS;
      end
      PH_NAL_DATA, PH_SPS_DATA, PH_PPS_DATA: begin
        has_grp         = 1'b1;
        grp_o.sc        = 1'b0;
        grp_o.kind      = (phase_q == PH_SPS_DATA) ? KIND_SPS :
                          (phase_q == PH_PPS_DATA) ? KIND_PPS : KIND_NAL;
        grp_o.unit_end  = dat_done || in_last_q;
        grp_o.truncated = !dat_done && in_last_q;
      end
      default: begin
        has_grp = 1'b0;
      end
    endcase
  end

  assign grp_valid_o = in_vld_q && has_grp;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_CODEC;
      offset_q   <= 4'd0;
      len_size_q <= LEN_SIZE_RST;
      accum_q    <= 32'd0;
      left_q     <= 32'd0;
      cnt_q      <= 3'd0;
    end else if (fire) begin
      phase_q    <= phase_d;
      offset_q   <= offset_d;
      len_size_q <= len_size_d;
      accum_q    <= accum_d;
      left_q     <= left_d;
      cnt_q      <= cnt_d;
    end
  end

endmodule

FILE: hdl/avclp_serializer.sv
// avclp_serializer: result register that plays out one group as one or four beats
// depends on avclp_pkg; fed by avclp_parser
module avclp_serializer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          grp_valid_i,
  input  avclp_pkg::grp_t grp_i,
  output logic          take_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    stream_byte_o,
  output logic          is_start_code_o,
  output logic [1:0]    unit_kind_o,
  output logic          unit_end_o,
  output logic          truncated_o,
  output logic          last_o
);
  import avclp_pkg::*;

  logic       vld_q;
  grp_t       grp_q;
  logic [1:0] idx_q;
  logic       final_beat;

  assign final_beat = !grp_q.sc || (idx_q == SC_LAST_IDX);
  assign take_o     = !vld_q || (out_ready_i && final_beat);

  // group register and beat index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 2'd0;
    end else if (take_o) begin
      vld_q <= grp_valid_i;
      idx_q <= 2'd0;
    end else if (out_ready_i) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && grp_valid_i) begin
      grp_q <= grp_i;
    end
  end

  // beat payload
  assign out_valid_o     = vld_q;
  assign stream_byte_o   = !grp_q.sc ? grp_q.data :
                           (idx_q == SC_LAST_IDX) ? SC_LAST_BYTE : SC_ZERO_BYTE;
  assign is_start_code_o = grp_q.sc;
  assign unit_kind_o     = grp_q.kind;
  assign unit_end_o      = final_beat && grp_q.unit_end;
  assign truncated_o     = final_beat && grp_q.truncated;
  assign last_o          = final_beat;

endmodule

FILE: hdl/avc_length_prefix_to_start_code.sv
// avc_length_prefix_to_start_code: FLV video tag payload to Annex B byte stream
// path: parser input register, then serializer group register, to the first output beat
// throughput: one input beat per cycle for header and unit data bytes when not stalled;
//   the last byte of a length prefix plays out a four-beat start code, holding the input
// reset: asynchronous, clears the parser to wait for a codec byte, length size to 4
// depends on avclp_pkg, avclp_if, avclp_parser, avclp_serializer
module avc_length_prefix_to_start_code (
  input  logic        clk_i,
  input  logic        rst_ni,
  avclp_in_if.sink    in_i,
  avclp_out_if.source out_o
);
  import avclp_pkg::*;

  logic take;
  logic grp_valid;
  grp_t grp;

  // parser stage
  avclp_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .tag_byte_i    (in_i.tag_byte),
    .last_of_tag_i (in_i.last_of_tag),
    .take_i        (take),
    .grp_valid_o   (grp_valid),
    .grp_o         (grp)
  );

  // output stage
  avclp_serializer u_serializer (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .grp_valid_i     (grp_valid),
    .grp_i           (grp),
    .take_o          (take),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .stream_byte_o   (out_o.stream_byte),
    .is_start_code_o (out_o.is_start_code),
    .unit_kind_o     (out_o.unit_kind),
    .unit_end_o      (out_o.unit_end),
    .truncated_o     (out_o.truncated),
    .last_o          (out_o.last)
  );

endmodule

FILE: hdl/avclp_checker.sv
// avclp_checker: port-level assertions on the converter output channel
// depends on avclp_pkg; bound to avc_length_prefix_to_start_code
module avclp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] stream_byte_i,
  input logic       is_start_code_i,
  input logic [1:0] unit_kind_i,
  input logic       unit_end_i,
  input logic       truncated_i,
  input logic       last_i
);
  import avclp_pkg::*;

  // a stalled beat stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  // a data byte is always the sole result of its input beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !is_start_code_i |-> last_i)
    else $error("data beat not marked last");

  // leading zero bytes of a start code are never the final result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_start_code_i && (stream_byte_i == SC_ZERO_BYTE)
      |-> !last_i && !unit_end_i)
    else $error("start code zero byte marked final");

  // truncation closes the unit on the final result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && truncated_i |-> unit_end_i && last_i)
    else $error("truncated beat does not end the unit");

  // after a start code zero byte is taken, the next beat continues the same start code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && is_start_code_i && !last_i
      |=> out_valid_i && is_start_code_i && (unit_kind_i == $past(unit_kind_i)))
    else $error("start code interrupted");

endmodule

bind avc_length_prefix_to_start_code avclp_checker u_avclp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .stream_byte_i   (out_o.stream_byte),
  .is_start_code_i (out_o.is_start_code),
  .unit_kind_i     (out_o.unit_kind),
  .unit_end_i      (out_o.unit_end),
  .truncated_i     (out_o.truncated),
  .last_i          (out_o.last)
);

FILE: tb/tb_avc_length_prefix_to_start_code.sv
// tb_avc_length_prefix_to_start_code: self-checking bench of the FLV tag to Annex B converter
// drives payload beats through avclp_in_if, checks avclp_out_if beats against a local predictor
// depends on avclp_pkg, avclp_if and avc_length_prefix_to_start_code
module tb_avc_length_prefix_to_start_code;
  import avclp_pkg::*;

  localparam int OFFSET_BITS = 24;
  localparam int N_RANDOM    = 460;
  localparam int HOLD_AFTER  = 150;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 16;

  // one expected output beat
  typedef struct packed {
    logic [7:0] data;
    logic       sc;
    logic [1:0] kind;
    logic       unit_end;
    logic       truncated;
    logic       last;
  } annexb_beat_t;

  // how a payload beat is checked: by the predictor, as silent, or against one typed beat
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_SILENT,
    CHK_SINGLE
  } chk_e;

  typedef struct packed {
    logic [7:0]   tag_byte;
    logic         last_of_tag;
    chk_e         chk;
    annexb_beat_t single;
  } payload_beat_t;

  localparam annexb_beat_t NO_BEAT = '0;

  // directed tags: non-avc codec, unknown packet type, config record, short coded unit
  localparam int N_DIRECTED = 28;
  localparam payload_beat_t DIRECTED [N_DIRECTED] = '{
    // codec 2, tag of one byte
    '{8'hF2, 1'b1, CHK_SILENT, NO_BEAT},
    // avc with packet type 2
    '{8'h17, 1'b0, CHK_SILENT, NO_BEAT},
    '{8'h02, 1'b1, CHK_SILENT, NO_BEAT},
    // config record, one-byte length prefixes, sps of one byte, empty pps at tag end
    '{8'h17, 1'b0, CHK_SILENT, NO_BEAT},
    '{8'h00, 1'b0, CHK_SILENT, NO_BEAT},
    '{8'h00, 1'b0, CHK_SILENT, NO_BEAT},
    '{8'h00, 1'b0, CHK_SILENT, NO_BEAT},
    '{8'h00, 1'b0, CHK_SILENT, NO_BEAT},
    '{8'h01, 1'b0, CHK_SILENT, NO_BEAT},
    '{8'h64, 1'b0, CHK_SILENT, NO_BEAT},
    '{8'h00, 1'b0, CHK_SILENT, NO_BEAT},
    '{8'h1F, 1'b0, CHK_SILENT, NO_BEAT},
    '{8'hFC, 1'b0, CHK_SILENT, NO_BEAT},
    '{8'hE1, 1'b0, CHK_SILENT, NO_BEAT},
    '{8'h00, 1'b0, CHK_SILENT, NO_BEAT},
    '{8'h01, 1'b0, CHK_MODEL,  NO_BEAT},
    '{8'h67, 1'b0, CHK_SINGLE, '{8'h67, 1'b0, KIND_SPS, 1'b1, 1'b0, 1'b1}},
    '{8'h01, 1'b0, CHK_SILENT, NO_BEAT},
    '{8'h00, 1'b0, CHK_SILENT, NO_BEAT},
    '{8'h00, 1'b1, CHK_MODEL,  NO_BEAT},
    // coded unit of three bytes cut short by the tag end
    '{8'h27, 1'b0, CHK_SILENT, NO_BEAT},
    '{8'h01, 1'b0, CHK_SILENT, NO_BEAT},
    '{8'h00, 1'b0, CHK_SILENT, NO_BEAT},
    '{8'h00, 1'b0, CHK_SILENT, NO_BEAT},
    '{8'h00, 1'b0, CHK_SILENT, NO_BEAT},
    '{8'h03, 1'b0, CHK_MODEL,  NO_BEAT},
    '{8'hFF, 1'b0, CHK_SINGLE, '{8'hFF, 1'b0, KIND_NAL, 1'b0, 1'b0, 1'b1}},
    '{8'h00, 1'b1, CHK_SINGLE, '{8'h00, 1'b0, KIND_NAL, 1'b1, 1'b1, 1'b1}}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  avclp_in_if  in_bus ();
  avclp_out_if out_bus ();

  avc_length_prefix_to_start_code i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // converter state of the predictor
  phase_e                 conv_phase    = PH_CODEC;
  logic [OFFSET_BITS-1:0] conv_offset   = '0;
  logic [2:0]             conv_len_size = LEN_SIZE_RST;
  logic [31:0]            conv_accum    = '0;
  logic [31:0]            conv_left     = '0;
  logic [2:0]             conv_pcount   = '0;

  annexb_beat_t  step_q[$];
  annexb_beat_t  annexb_q[$];
  payload_beat_t feed_q[$];
  logic [7:0]    tag_buf[$];
  annexb_beat_t  want;

  int n_in = 0;
  int n_fail = 0;
  int gen_len_size = LEN_SIZE_RST;
  int tx_burst = 0;
  int rx_burst = 0;
  bit held = 1'b0;

  // start code that opens a unit of len bytes, gives the phase after it
  function automatic phase_e open_unit(logic [1:0] kind, logic [31:0] len, logic end_tag,
                                       phase_e data_ph, phase_e after_ph);
    logic zero;
    logic tr;
    zero = (len == 32'd0);
    tr = !zero && end_tag;
    for (int i = 0; i < 4; i++) begin
      step_q.insert(step_q.size(),
                    '{data: (i == 3) ? SC_LAST_BYTE : SC_ZERO_BYTE, sc: 1'b1, kind: kind,
                      unit_end: (i == 3) && (zero || tr), truncated: (i == 3) && tr,
                      last: 1'b0});
    end
    conv_left = len;
    return zero ? after_ph : data_ph;
  endfunction

  // one data byte of the open unit
  function automatic phase_e unit_data(logic [7:0] b, logic [1:0] kind, logic end_tag,
                                       phase_e after_ph);
    logic done;
    conv_left = conv_left - 32'd1;
    done = (conv_left == 32'd0);
    step_q.insert(step_q.size(), '{data: b, sc: 1'b0, kind: kind, unit_end: done || end_tag,
                                   truncated: !done && end_tag, last: 1'b0});
    return done ? after_ph : conv_phase;
  endfunction

  // advance the converter by one payload byte, beats land in step_q
  function automatic void convert_byte(logic [7:0] b, logic end_tag);
    case (conv_phase)
      PH_CODEC: begin
        conv_phase = (b[3:0] == AVC_CODEC) ? PH_TYPE : PH_IGNORE;
      end
      PH_TYPE: begin
        conv_phase = (b == PKT_CONFIG) ? PH_CFG_HDR : (b == PKT_NALU) ? PH_NAL_HDR : PH_IGNORE;
      end
      PH_NAL_HDR: begin
        if (conv_offset >= NAL_HDR_LAST) begin
          conv_phase = PH_PREFIX;
          conv_pcount = '0;
          conv_accum = '0;
        end
      end
      PH_PREFIX: begin
        conv_accum = {conv_accum[23:0], b};
        conv_pcount = conv_pcount + 3'd1;
        if (conv_pcount >= conv_len_size) begin
          conv_phase = open_unit(KIND_NAL, conv_accum, end_tag, PH_NAL_DATA, PH_PREFIX);
          conv_pcount = '0;
          conv_accum = '0;
        end
      end
      PH_NAL_DATA: begin
        conv_phase = unit_data(b, KIND_NAL, end_tag, PH_PREFIX);
      end
      PH_CFG_HDR: begin
        if (conv_offset == CFG_LEN_SIZE) conv_len_size = {1'b0, b[1:0]} + 3'd1;
        if (conv_offset >= CFG_HDR_LAST) begin
          conv_phase = PH_SPS_LEN;
          conv_pcount = '0;
          conv_accum = '0;
        end
      end
      PH_SPS_LEN, PH_PPS_LEN: begin
        conv_accum = {16'h0000, conv_accum[7:0], b};
        conv_pcount = conv_pcount + 3'd1;
        if (conv_pcount >= PS_LEN_BYTES) begin
          if (conv_phase == PH_SPS_LEN)
            conv_phase = open_unit(KIND_SPS, conv_accum, end_tag, PH_SPS_DATA, PH_PPS_CNT);
          else
            conv_phase = open_unit(KIND_PPS, conv_accum, end_tag, PH_PPS_DATA, PH_IGNORE);
          conv_pcount = '0;
          conv_accum = '0;
        end
      end
      PH_SPS_DATA: begin
        conv_phase = unit_data(b, KIND_SPS, end_tag, PH_PPS_CNT);
      end
      PH_PPS_CNT: begin
        conv_phase = PH_PPS_LEN;
        conv_pcount = '0;
        conv_accum = '0;
      end
      PH_PPS_DATA: begin
        conv_phase = unit_data(b, KIND_PPS, end_tag, PH_IGNORE);
      end
      default: begin
        conv_phase = PH_IGNORE;
      end
    endcase

    if (conv_offset != '1) conv_offset = conv_offset + 1'b1;

    // tag end clears everything but the length size
    if (end_tag) begin
      conv_phase = PH_CODEC;
      conv_offset = '0;
      conv_accum = '0;
      conv_left = '0;
      conv_pcount = '0;
    end
  endfunction

  // cycles to wait before the next beat, with bursts of back-to-back beats
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  // append one byte to the tag under construction
  function automatic void add_byte(logic [7:0] b);
    tag_buf.insert(tag_buf.size(), b);
  endfunction

  // append one random tag to feed_q, returns its number of beats, or zero for another codec or packet type
  function automatic int gen_tag();
    int kind;
    int units;
    int n_data;
    int cut;
    logic [31:0] len;
    logic [7:0] b0;
    bit counted;
    bit huge;
    tag_buf.delete();
    counted = 1'b1;
    kind = $urandom_range(0, 99);
    if (kind < 50) begin
      // coded units behind length prefixes
      add_byte({4'($urandom), AVC_CODEC});
      add_byte(PKT_NALU);
      repeat (3) add_byte(8'($urandom));
      units = $urandom_range(1, 3);
      for (int u = 0; u < units; u++) begin
        huge = ($urandom_range(0, 19) == 0);
        if (huge) len = $urandom;
        else if ($urandom_range(0, 9) == 0) len = $urandom_range(7, 40);
        else len = $urandom_range(0, 6);
        if (gen_len_size < 4) len = len & ((32'd1 << (8 * gen_len_size)) - 32'd1);
        for (int k = gen_len_size - 1; k >= 0; k--) add_byte(8'(len >> (8 * k)));
        n_data = huge ? $urandom_range(0, 8) : int'(len);
        if (n_data > len) n_data = len;
        repeat (n_data) add_byte(8'($urandom));
        if (n_data < len) break;
      end
    end else if (kind < 72) begin
      // config record with one sps and one pps
      add_byte({4'($urandom), AVC_CODEC});
      add_byte(PKT_CONFIG);
      repeat (9) add_byte(8'($urandom));
      for (int p = 0; p < 2; p++) begin
        if (p == 1) add_byte(8'($urandom));
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 30) : $urandom_range(0, 6);
        add_byte(len[15:8]);
        add_byte(len[7:0]);
        repeat (len) add_byte(8'($urandom));
      end
      repeat ($urandom_range(0, 2)) add_byte(8'($urandom));
    end else if (kind < 86) begin
      // other codec or unknown packet type
      counted = 1'b0;
      b0 = 8'($urandom);
      if ($urandom_range(0, 1) == 1) begin
        if (b0[3:0] == AVC_CODEC) b0[0] = 1'b0;
        add_byte(b0);
      end else begin
        add_byte({b0[7:4], AVC_CODEC});
        add_byte(8'($urandom_range(2, 255)));
      end
      repeat ($urandom_range(0, 4)) add_byte(8'($urandom));
    end else begin
      // raw garbage, half of it marked as avc
      repeat ($urandom_range(1, 12)) add_byte(8'($urandom));
      if ($urandom_range(0, 1) == 1) tag_buf[0] = {tag_buf[0][7:4], AVC_CODEC};
    end

    // tag cut short anywhere
    if (kind < 72 && $urandom_range(0, 6) == 0) begin
      cut = $urandom_range(1, tag_buf.size());
      while (tag_buf.size() > cut) void'(tag_buf.pop_back());
    end

    // track the length size that the block will hold after this tag
    if (tag_buf.size() >= 10 && tag_buf[0][3:0] == AVC_CODEC && tag_buf[1] == PKT_CONFIG)
      gen_len_size = int'(tag_buf[CFG_LEN_SIZE][1:0]) + 1;

    foreach (tag_buf[k]) begin
      feed_q.insert(feed_q.size(), '{tag_byte: tag_buf[k],
                                     last_of_tag: (k == tag_buf.size() - 1),
                                     chk: CHK_MODEL, single: NO_BEAT});
    end
    return counted ? tag_buf.size() : 0;
  endfunction

  // predict on accepted input beats, check accepted output beats
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        step_q.delete();
        convert_byte(in_bus.tag_byte, in_bus.last_of_tag);
        if (step_q.size() != 0) step_q[step_q.size() - 1].last = 1'b1;
        case (feed_q[n_in].chk)
          CHK_MODEL:  foreach (step_q[k]) annexb_q.insert(annexb_q.size(), step_q[k]);
          CHK_SINGLE: annexb_q.insert(annexb_q.size(), feed_q[n_in].single);
          default:    ;
        endcase
        n_in++;
      end
      if (out_bus.valid && out_bus.ready) begin
        if (annexb_q.size() == 0) begin
          $error("output beat with nothing expected: stream_byte %h", out_bus.stream_byte);
          n_fail++;
        end else begin
          want = annexb_q.pop_front();
          if (out_bus.stream_byte !== want.data) begin
            $error("stream_byte expected %h got %h", want.data, out_bus.stream_byte);
            n_fail++;
          end
          if (out_bus.is_start_code !== want.sc) begin
            $error("is_start_code expected %b got %b", want.sc, out_bus.is_start_code);
            n_fail++;
          end
          if (out_bus.unit_kind !== want.kind) begin
            $error("unit_kind expected %0d got %0d", want.kind, out_bus.unit_kind);
            n_fail++;
          end
          if (out_bus.unit_end !== want.unit_end) begin
            $error("unit_end expected %b got %b", want.unit_end, out_bus.unit_end);
            n_fail++;
          end
          if (out_bus.truncated !== want.truncated) begin
            $error("truncated expected %b got %b", want.truncated, out_bus.truncated);
            n_fail++;
          end
          if (out_bus.last !== want.last) begin
            $error("last expected %b got %b", want.last, out_bus.last);
            n_fail++;
          end
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off so the block backs up
  initial begin
    int gap;
    out_bus.ready <= 1'b0;
    wait (rst_n);
    forever begin
      if (!held && n_in >= HOLD_AFTER) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end
      gap = draw_gap(rx_burst);
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
      while (!out_bus.valid) @(posedge clk);
    end
  end

  // watchdog on cycles without any beat
  initial begin
    int idle;
    idle = 0;
    wait (rst_n);
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) idle = 0;
      else idle++;
    end
    $display("avc_length_prefix_to_start_code test failed");
    $finish;
  end

  // reset, stimulus, sender and end of run
  initial begin
    int gap;
    int counted;
    in_bus.valid <= 1'b0;
    in_bus.tag_byte <= '0;
    in_bus.last_of_tag <= 1'b0;

    foreach (DIRECTED[r]) feed_q.insert(feed_q.size(), DIRECTED[r]);
    // the directed config record selects one-byte prefixes
    gen_len_size = 1;
    counted = N_DIRECTED;
    while (counted < N_RANDOM) counted += gen_tag();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < feed_q.size(); i++) begin
      gap = draw_gap(tx_burst);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_bus.valid <= 1'b1;
      in_bus.tag_byte <= feed_q[i].tag_byte;
      in_bus.last_of_tag <= feed_q[i].last_of_tag;
      @(posedge clk);
      while (!in_bus.ready) @(posedge clk);
    end
    in_bus.valid <= 1'b0;

    // every input beat predicted and every expected beat seen
    while (n_in < feed_q.size() || annexb_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_fail == 0) begin
      $display("avc_length_prefix_to_start_code test passed");
    end else begin
      $display("avc_length_prefix_to_start_code test failed");
    end
    $finish;
  end

endmodule
